/* design/hv_supply_setpoint_regulator_core_defines.svh */
// Assertion macros for the setpoint regulator core.
// Used by the core top level in this folder; expects i_clk and i_rst_n in scope.
`ifndef HV_SUPPLY_SETPOINT_REGULATOR_CORE_DEFINES_SVH
`define HV_SUPPLY_SETPOINT_REGULATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define HVSR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define HVSR_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define HVSR_ASSERT(lbl, prop, msg)
`define HVSR_ASSERT_RST(lbl, prop, msg)
`endif

`endif

/* design/hvsr_pkg.sv */
// Shared types and constants of the setpoint regulator core.
// No dependencies; the RTL files refer to it by scoped names, the testbench imports it.
`timescale 1ns / 1ps

package hvsr_pkg;

    localparam int DW      = 12;
    localparam int STEP_W  = 8;
    localparam int GAIN_W  = 14;
    localparam int ERR_W   = 13;
    localparam int ACC_W   = 30;
    localparam int FRAC_W  = 12;
    localparam int SUM_W   = 16;
    localparam int CFG_DW  = 14;
    localparam int CFG_AW  = 3;

    localparam logic [CFG_AW-1:0] CFG_SP_MIN    = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_SP_MAX    = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_STEP      = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_ERR_LIM   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_GAIN_NOW  = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_GAIN_PREV = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_DRIVE_MAX = 3'd6;

    localparam logic [DW-1:0]     RST_SP_MIN    = 12'd250;
    localparam logic [DW-1:0]     RST_SP_MAX    = 12'd3750;
    localparam logic [STEP_W-1:0] RST_STEP      = 8'd10;
    localparam logic [DW-1:0]     RST_ERR_LIM   = 12'd500;
    localparam logic [GAIN_W-1:0] RST_GAIN_NOW  = 14'd4676;
    localparam logic [GAIN_W-1:0] RST_GAIN_PREV = 14'd2904;
    localparam logic [DW-1:0]     RST_DRIVE_MAX = 12'd4095;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_STEP   = 2'd1,
        MODE_SWITCH = 2'd2,
        MODE_IDLE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        TONE_NONE  = 2'd0,
        TONE_STEP  = 2'd1,
        TONE_LIMIT = 2'd2
    } t_tone;

    typedef struct packed {
        t_mode          mode;
        logic [DW-1:0]  voltage_code;
        logic [DW-1:0]  current_code;
        logic           clk_level;
        logic           dir_level;
        logic           switch_level;
    } t_in_word;

    typedef struct packed {
        logic           dac_write;
        logic [DW-1:0]  dac_value;
        logic           hv_enable;
        logic [DW-1:0]  setpoint;
        t_tone          tone;
        logic           avg_valid;
        logic [DW-1:0]  avg_voltage;
        logic [DW-1:0]  avg_current;
        logic           voltage_changed;
        logic           current_changed;
    } t_out_word;

    typedef struct packed {
        logic [DW-1:0]     sp_min;
        logic [DW-1:0]     sp_max;
        logic [STEP_W-1:0] step_size;
        logic [DW-1:0]     err_limit;
        logic [GAIN_W-1:0] gain_now;
        logic [GAIN_W-1:0] gain_prev;
        logic [DW-1:0]     drive_max;
    } t_cfg;

    typedef struct packed {
        logic                    write;
        logic [DW-1:0]           drive;
        logic signed [ERR_W-1:0] err;
    } t_pi_res;

    typedef struct packed {
        logic          valid;
        logic [DW-1:0] avg_v;
        logic [DW-1:0] avg_i;
        logic          v_chg;
        logic          i_chg;
    } t_avg_res;

endpackage

/* design/hvsr_cfg.sv */
// Configuration register file of the setpoint regulator core.
// Depends on hvsr_pkg.
`timescale 1ns / 1ps

module hvsr_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [hvsr_pkg::CFG_AW-1:0] i_cfg_idx,
    input  logic [hvsr_pkg::CFG_DW-1:0] i_cfg_data,
    output hvsr_pkg::t_cfg              o_cfg
);

    hvsr_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sp_min    <= hvsr_pkg::RST_SP_MIN;
            r_cfg.sp_max    <= hvsr_pkg::RST_SP_MAX;
            r_cfg.step_size <= hvsr_pkg::RST_STEP;
            r_cfg.err_limit <= hvsr_pkg::RST_ERR_LIM;
            r_cfg.gain_now  <= hvsr_pkg::RST_GAIN_NOW;
            r_cfg.gain_prev <= hvsr_pkg::RST_GAIN_PREV;
            r_cfg.drive_max <= hvsr_pkg::RST_DRIVE_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hvsr_pkg::CFG_SP_MIN:    r_cfg.sp_min    <= i_cfg_data[hvsr_pkg::DW-1:0];
                hvsr_pkg::CFG_SP_MAX:    r_cfg.sp_max    <= i_cfg_data[hvsr_pkg::DW-1:0];
                hvsr_pkg::CFG_STEP:      r_cfg.step_size <= i_cfg_data[hvsr_pkg::STEP_W-1:0];
                hvsr_pkg::CFG_ERR_LIM:   r_cfg.err_limit <= i_cfg_data[hvsr_pkg::DW-1:0];
                hvsr_pkg::CFG_GAIN_NOW:  r_cfg.gain_now  <= i_cfg_data[hvsr_pkg::GAIN_W-1:0];
                hvsr_pkg::CFG_GAIN_PREV: r_cfg.gain_prev <= i_cfg_data[hvsr_pkg::GAIN_W-1:0];
                hvsr_pkg::CFG_DRIVE_MAX: r_cfg.drive_max <= i_cfg_data[hvsr_pkg::DW-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* design/hvsr_pi.sv */
// Incremental PI law: error clamp, two Q12 products, output clamp.
// Depends on hvsr_pkg; purely combinational.
`timescale 1ns / 1ps

module hvsr_pi (
    input  hvsr_pkg::t_cfg                     i_cfg,
    input  logic [hvsr_pkg::DW-1:0]            i_target,
    input  logic [hvsr_pkg::DW-1:0]            i_vcode,
    input  logic signed [hvsr_pkg::ERR_W-1:0]  i_last_err,
    input  logic [hvsr_pkg::DW-1:0]            i_last_drive,
    output hvsr_pkg::t_pi_res                  o_res
);

    localparam int PW = hvsr_pkg::ERR_W + hvsr_pkg::GAIN_W + 1;
    localparam int PAD = hvsr_pkg::ACC_W - hvsr_pkg::DW - hvsr_pkg::FRAC_W;
    localparam int QW = hvsr_pkg::ACC_W - 1 - hvsr_pkg::FRAC_W;

    logic signed [hvsr_pkg::ERR_W-1:0]  e_raw;
    logic signed [hvsr_pkg::ERR_W-1:0]  lim;
    logic signed [hvsr_pkg::ERR_W-1:0]  e_hi;
    logic signed [hvsr_pkg::ERR_W-1:0]  e_clip;
    logic signed [hvsr_pkg::GAIN_W:0]   g_now;
    logic signed [hvsr_pkg::GAIN_W:0]   g_prev;
    logic signed [PW-1:0]               prod_now;
    logic signed [PW-1:0]               prod_prev;
    logic signed [hvsr_pkg::ACC_W-1:0]  term_d;
    logic signed [hvsr_pkg::ACC_W-1:0]  acc;
    logic [QW-1:0]                      q;
    logic [hvsr_pkg::DW-1:0]            q_top;
    logic [hvsr_pkg::DW-1:0]            drive;

    always_comb begin
        e_raw  = $signed({1'b0, i_target}) - $signed({1'b0, i_vcode});
        lim    = $signed({1'b0, i_cfg.err_limit});
        e_hi   = (e_raw > lim) ? lim : e_raw;
        e_clip = (e_hi < -lim) ? -lim : e_hi;

        g_now     = $signed({1'b0, i_cfg.gain_now});
        g_prev    = $signed({1'b0, i_cfg.gain_prev});
        prod_now  = PW'(e_clip) * PW'(g_now);
        prod_prev = PW'(i_last_err) * PW'(g_prev);
        term_d    = $signed({{PAD{1'b0}}, i_last_drive, {hvsr_pkg::FRAC_W{1'b0}}});
        acc       = term_d + hvsr_pkg::ACC_W'(prod_now) - hvsr_pkg::ACC_W'(prod_prev);

        q     = acc[hvsr_pkg::ACC_W-2:hvsr_pkg::FRAC_W];
        q_top = (q > QW'(i_cfg.drive_max)) ? i_cfg.drive_max : q[hvsr_pkg::DW-1:0];
        if (acc[hvsr_pkg::ACC_W-1]) begin
            drive = i_cfg.sp_min;
        end else if (q_top <= i_cfg.sp_min) begin
            drive = i_cfg.sp_min;
        end else begin
            drive = q_top;
        end

        o_res.write = (drive != i_last_drive);
        o_res.drive = drive;
        o_res.err   = e_clip;
    end

endmodule

/* design/hvsr_avg.sv */
// Block averager of the ADC codes with change flags against the last block.
// Depends on hvsr_pkg; divides by the block length through a reciprocal multiply.
`timescale 1ns / 1ps

module hvsr_avg #(
    parameter int AVG_COUNT = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_sample,
    input  logic [hvsr_pkg::DW-1:0] i_vcode,
    input  logic [hvsr_pkg::DW-1:0] i_icode,
    output hvsr_pkg::t_avg_res      o_res
);

    localparam int CW     = $clog2(AVG_COUNT);
    localparam int SHIFT  = 20;
    localparam int RW     = 20;
    localparam int MW     = hvsr_pkg::SUM_W + RW;
    localparam logic [RW-1:0] RECIP = RW'(((1 << SHIFT) + AVG_COUNT - 1) / AVG_COUNT);

    logic [CW-1:0]                r_cnt;
    logic [hvsr_pkg::SUM_W-1:0]   r_sum_v;
    logic [hvsr_pkg::SUM_W-1:0]   r_sum_i;
    logic [hvsr_pkg::DW-1:0]      r_prior_v;
    logic [hvsr_pkg::DW-1:0]      r_prior_i;
    logic [hvsr_pkg::SUM_W-1:0]   n_sum_v;
    logic [hvsr_pkg::SUM_W-1:0]   n_sum_i;
    logic [MW-1:0]                prod_v;
    logic [MW-1:0]                prod_i;
    logic [hvsr_pkg::DW-1:0]      q_v;
    logic [hvsr_pkg::DW-1:0]      q_i;
    logic                         last;

    always_comb begin
        n_sum_v = r_sum_v + hvsr_pkg::SUM_W'(i_vcode);
        n_sum_i = r_sum_i + hvsr_pkg::SUM_W'(i_icode);
        prod_v  = MW'(n_sum_v) * MW'(RECIP);
        prod_i  = MW'(n_sum_i) * MW'(RECIP);
        q_v     = prod_v[SHIFT +: hvsr_pkg::DW];
        q_i     = prod_i[SHIFT +: hvsr_pkg::DW];
        last    = (r_cnt == CW'(AVG_COUNT - 1));

        o_res.valid = last;
        o_res.avg_v = last ? q_v : '0;
        o_res.avg_i = last ? q_i : '0;
        o_res.v_chg = last && (q_v != r_prior_v);
        o_res.i_chg = last && (q_i != r_prior_i);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_sum_v   <= '0;
            r_sum_i   <= '0;
            r_prior_v <= '0;
            r_prior_i <= '0;
        end else if (i_sample) begin
            if (last) begin
                r_cnt     <= '0;
                r_sum_v   <= '0;
                r_sum_i   <= '0;
                r_prior_v <= q_v;
                r_prior_i <= q_i;
            end else begin
                r_cnt   <= r_cnt + CW'(1);
                r_sum_v <= n_sum_v;
                r_sum_i <= n_sum_i;
            end
        end
    end

endmodule

/* design/hv_supply_setpoint_regulator_core.sv */
// Top level of the high-voltage supply setpoint regulator core.
// Depends on hvsr_pkg, hvsr_cfg, hvsr_pi, hvsr_avg and the assertion macro header.
//
//   port group  direction  handshake             payload
//   in          to core    i_in_valid/o_in_stall i_in_word   (hvsr_pkg::t_in_word)
//   out         from core  o_out_valid/i_out_stall o_out_word (hvsr_pkg::t_out_word)
//   cfg         to core    i_cfg_we              i_cfg_idx, i_cfg_data
//
// One word per cycle sustained while the output is not stalled; each word gives
// exactly one result word via the input register, then the result register.
// The setpoint, PI and averager state update at the result register load, so
// a following word in the next cycle sees it.
// Reset: setpoint 250, supply enabled, regulator and averages cleared.
// A stalled result holds; the input register holds behind it and stalls input.
`timescale 1ns / 1ps
`include "hv_supply_setpoint_regulator_core_defines.svh"

module hv_supply_setpoint_regulator_core #(
    parameter int AVG_COUNT = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  hvsr_pkg::t_in_word          i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output hvsr_pkg::t_out_word         o_out_word,
    input  logic                        i_cfg_we,
    input  logic [hvsr_pkg::CFG_AW-1:0] i_cfg_idx,
    input  logic [hvsr_pkg::CFG_DW-1:0] i_cfg_data
);

    hvsr_pkg::t_cfg        cfg;
    hvsr_pkg::t_pi_res     pi_res;
    hvsr_pkg::t_avg_res    avg_res;

    logic                  r_in_vld;
    hvsr_pkg::t_in_word    r_in;
    logic                  r_out_vld;
    hvsr_pkg::t_out_word   r_out;

    logic [hvsr_pkg::DW-1:0]           r_target;
    logic signed [hvsr_pkg::ERR_W-1:0] r_last_err;
    logic [hvsr_pkg::DW-1:0]           r_last_drive;
    logic                              r_enabled;

    logic [hvsr_pkg::DW-1:0]           n_target;
    logic signed [hvsr_pkg::ERR_W-1:0] n_last_err;
    logic [hvsr_pkg::DW-1:0]           n_last_drive;
    logic                              n_enabled;
    hvsr_pkg::t_out_word               n_out;

    logic                  adv;
    logic                  take_in;
    logic                  sample;
    logic signed [hvsr_pkg::DW+1:0] t_dn;
    logic [hvsr_pkg::DW:0]          t_up;

    assign adv         = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall  = r_in_vld && !adv;
    assign take_in     = i_in_valid && !o_in_stall;
    assign sample      = adv && (r_in.mode == hvsr_pkg::MODE_SAMPLE);
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    hvsr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    hvsr_pi u_pi (
        .i_cfg        (cfg),
        .i_target     (r_target),
        .i_vcode      (r_in.voltage_code),
        .i_last_err   (r_last_err),
        .i_last_drive (r_last_drive),
        .o_res        (pi_res)
    );

    hvsr_avg #(
        .AVG_COUNT (AVG_COUNT)
    ) u_avg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample),
        .i_vcode  (r_in.voltage_code),
        .i_icode  (r_in.current_code),
        .o_res    (avg_res)
    );

    always_comb begin
        n_target     = r_target;
        n_last_err   = r_last_err;
        n_last_drive = r_last_drive;
        n_enabled    = r_enabled;
        n_out        = '0;
        t_dn = $signed({2'b00, r_target}) - $signed({6'b0, cfg.step_size});
        t_up = {1'b0, r_target} + (hvsr_pkg::DW + 1)'(cfg.step_size);

        unique case (r_in.mode)
            hvsr_pkg::MODE_SAMPLE: begin
                if (r_enabled) begin
                    n_last_err      = pi_res.err;
                    n_last_drive    = pi_res.drive;
                    n_out.dac_write = pi_res.write;
                    n_out.dac_value = pi_res.write ? pi_res.drive : '0;
                end
                n_out.avg_valid       = avg_res.valid;
                n_out.avg_voltage     = avg_res.avg_v;
                n_out.avg_current     = avg_res.avg_i;
                n_out.voltage_changed = avg_res.v_chg;
                n_out.current_changed = avg_res.i_chg;
            end
            hvsr_pkg::MODE_STEP: begin
                n_out.tone = hvsr_pkg::TONE_STEP;
                if (!r_in.clk_level) begin
                    if (!r_in.dir_level) begin
                        if (t_dn < $signed({2'b00, cfg.sp_min})) begin
                            n_target   = cfg.sp_min;
                            n_out.tone = hvsr_pkg::TONE_LIMIT;
                        end else begin
                            n_target = t_dn[hvsr_pkg::DW-1:0];
                        end
                    end else begin
                        if (t_up > {1'b0, cfg.sp_max}) begin
                            n_target   = cfg.sp_max;
                            n_out.tone = hvsr_pkg::TONE_LIMIT;
                        end else begin
                            n_target = t_up[hvsr_pkg::DW-1:0];
                        end
                    end
                end
            end
            hvsr_pkg::MODE_SWITCH: begin
                if (!r_in.switch_level) begin
                    n_target        = cfg.sp_min;
                    n_out.dac_write = 1'b1;
                    n_out.dac_value = cfg.sp_min;
                    n_enabled       = !r_enabled;
                    if (!r_enabled) begin
                        n_last_err   = '0;
                        n_last_drive = '0;
                    end
                end
            end
            hvsr_pkg::MODE_IDLE: begin
            end
        endcase

        n_out.hv_enable = n_enabled;
        n_out.setpoint  = n_target;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_target     <= hvsr_pkg::RST_SP_MIN;
            r_last_err   <= '0;
            r_last_drive <= '0;
            r_enabled    <= 1'b1;
        end else begin
            if (take_in) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld    <= 1'b1;
                r_target     <= n_target;
                r_last_err   <= n_last_err;
                r_last_drive <= n_last_drive;
                r_enabled    <= n_enabled;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in <= i_in_word;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    `HVSR_ASSERT(a_no_write_zero, o_out_valid && !o_out_word.dac_write |-> o_out_word.dac_value == '0, "dac value set without write")
    `HVSR_ASSERT(a_step_quiet, o_out_valid && o_out_word.tone != hvsr_pkg::TONE_NONE |-> !o_out_word.dac_write && !o_out_word.avg_valid, "step word carries write or average")
    `HVSR_ASSERT(a_avg_quiet, o_out_valid && !o_out_word.avg_valid |-> !o_out_word.voltage_changed && !o_out_word.current_changed && o_out_word.avg_voltage == '0, "average fields set without block end")
    `HVSR_ASSERT(a_disabled_quiet, adv && !r_enabled && r_in.mode == hvsr_pkg::MODE_SAMPLE |=> !r_out.dac_write && $stable(r_last_drive), "regulator ran while supply disabled")
    `HVSR_ASSERT_RST(a_reset_state, !i_rst_n |=> r_enabled && !r_in_vld && !r_out_vld && r_target == hvsr_pkg::RST_SP_MIN, "state not cleared by reset")

endmodule

/* test/hv_supply_setpoint_regulator_core_test.sv */
// Testbench for hv_supply_setpoint_regulator_core: directed and random words under random pacing.
// A built-in predictor tracks setpoint, PI drive, enable and block averages from hvsr_pkg types.
// Needs only the RTL: hvsr_pkg and the core with its submodules.
`timescale 1ns / 1ps

module hv_supply_setpoint_regulator_core_test;
    import hvsr_pkg::*;

    localparam int BLOCK_LEN = 16;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    t_in_word            in_word = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    t_out_word           out_word;
    logic                cfg_we = 1'b0;
    logic [CFG_AW-1:0]   cfg_idx = CFG_SP_MIN;
    logic [CFG_DW-1:0]   cfg_data = '0;

    t_cfg                knobs;
    logic [DW-1:0]       sp_target;
    int                  prev_err;
    logic [DW-1:0]       prev_drive;
    logic                hv_on;
    int                  n_samples;
    logic [SUM_W-1:0]    sum_v;
    logic [SUM_W-1:0]    sum_i;
    logic [DW-1:0]       prior_v;
    logic [DW-1:0]       prior_i;

    t_out_word           predicted_status[$];
    int                  mismatches = 0;
    bit                  quiet = 1'b0;
    int                  stall_pct = 25;
    int                  hold_left = 0;

    hv_supply_setpoint_regulator_core #(
        .AVG_COUNT(BLOCK_LEN)
    ) uut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_in_word(in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_word(out_word),
        .i_cfg_we(cfg_we),
        .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        #(20_000_000);
        $display("hv_supply_setpoint_regulator_core: mismatch");
        $finish;
    end

    function automatic void reset_model();
        knobs = '{RST_SP_MIN, RST_SP_MAX, RST_STEP, RST_ERR_LIM,
                  RST_GAIN_NOW, RST_GAIN_PREV, RST_DRIVE_MAX};
        sp_target  = RST_SP_MIN;
        prev_err   = 0;
        prev_drive = '0;
        hv_on      = 1'b1;
        n_samples  = 0;
        sum_v      = '0;
        sum_i      = '0;
        prior_v    = '0;
        prior_i    = '0;
    endfunction

    function automatic t_out_word compute_status(input t_in_word w);
        t_out_word     r;
        int            e;
        int            lim;
        int            t;
        longint        acc;
        longint        q;
        logic [DW-1:0] drive;
        r = '0;
        case (w.mode)
            MODE_SAMPLE: begin
                if (hv_on) begin
                    lim = int'(knobs.err_limit);
                    e = int'(sp_target) - int'(w.voltage_code);
                    if (e > lim) e = lim;
                    if (e < -lim) e = -lim;
                    acc = longint'(prev_drive) * 4096
                        + longint'(e) * longint'(knobs.gain_now)
                        - longint'(prev_err) * longint'(knobs.gain_prev);
                    if (acc < 0) begin
                        drive = knobs.sp_min;
                    end else begin
                        q = acc / 4096;
                        if (q > longint'(knobs.drive_max)) q = longint'(knobs.drive_max);
                        drive = q[DW-1:0];
                        if (drive <= knobs.sp_min) drive = knobs.sp_min;
                    end
                    if (drive != prev_drive) begin
                        r.dac_write = 1'b1;
                        r.dac_value = drive;
                    end
                    prev_drive = drive;
                    prev_err = e;
                end
                sum_v = sum_v + SUM_W'(w.voltage_code);
                sum_i = sum_i + SUM_W'(w.current_code);
                n_samples++;
                if (n_samples >= BLOCK_LEN) begin
                    r.avg_valid       = 1'b1;
                    r.avg_voltage     = DW'(sum_v / BLOCK_LEN);
                    r.avg_current     = DW'(sum_i / BLOCK_LEN);
                    r.voltage_changed = (r.avg_voltage != prior_v);
                    r.current_changed = (r.avg_current != prior_i);
                    prior_v   = r.avg_voltage;
                    prior_i   = r.avg_current;
                    sum_v     = '0;
                    sum_i     = '0;
                    n_samples = 0;
                end
            end
            MODE_STEP: begin
                r.tone = TONE_STEP;
                if (!w.clk_level) begin
                    t = int'(sp_target);
                    if (!w.dir_level) begin
                        t = t - int'(knobs.step_size);
                        if (t < int'(knobs.sp_min)) begin
                            t = int'(knobs.sp_min);
                            r.tone = TONE_LIMIT;
                        end
                    end else begin
                        t = t + int'(knobs.step_size);
                        if (t > int'(knobs.sp_max)) begin
                            t = int'(knobs.sp_max);
                            r.tone = TONE_LIMIT;
                        end
                    end
                    sp_target = t[DW-1:0];
                end
            end
            MODE_SWITCH: begin
                if (!w.switch_level) begin
                    sp_target   = knobs.sp_min;
                    r.dac_write = 1'b1;
                    r.dac_value = knobs.sp_min;
                    if (!hv_on) begin
                        prev_err   = 0;
                        prev_drive = '0;
                        hv_on      = 1'b1;
                    end else begin
                        hv_on = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
        r.hv_enable = hv_on;
        r.setpoint  = sp_target;
        return r;
    endfunction

    function automatic t_in_word make_word(input t_mode m, input logic [DW-1:0] v,
                                           input logic [DW-1:0] c, input logic ck,
                                           input logic dr, input logic sw);
        t_in_word w;
        w.mode         = m;
        w.voltage_code = v;
        w.current_code = c;
        w.clk_level    = ck;
        w.dir_level    = dr;
        w.switch_level = sw;
        return w;
    endfunction

    function automatic t_in_word random_word(input bit flat, input logic [DW-1:0] fv,
                                             input logic [DW-1:0] fi);
        t_in_word w;
        int       pick;
        int       v;
        pick = $urandom_range(0, 99);
        w.voltage_code = DW'($urandom_range(0, 4095));
        w.current_code = DW'($urandom_range(0, 4095));
        w.clk_level    = ($urandom_range(0, 4) == 0);
        w.dir_level    = 1'($urandom_range(0, 1));
        w.switch_level = 1'($urandom_range(0, 1));
        if (pick < 64) begin
            w.mode = MODE_SAMPLE;
            if (flat) begin
                w.voltage_code = fv;
                w.current_code = fi;
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    v = int'(sp_target) + int'($urandom_range(0, 1200)) - 600;
                else if (pick < 7)
                    v = int'(prev_drive) + int'($urandom_range(0, 64)) - 32;
                else
                    v = int'(w.voltage_code);
                if (v < 0) v = 0;
                if (v > 4095) v = 4095;
                w.voltage_code = v[DW-1:0];
            end
        end else if (pick < 88) begin
            w.mode = MODE_STEP;
        end else if (pick < 96) begin
            w.mode = MODE_SWITCH;
        end else begin
            w.mode = MODE_IDLE;
        end
        return w;
    endfunction

    function automatic t_cfg random_settings();
        t_cfg c;
        c.sp_min    = DW'($urandom_range(0, 600));
        c.sp_max    = DW'($urandom_range(3000, 4095));
        c.step_size = STEP_W'($urandom_range(1, 255));
        c.err_limit = DW'($urandom_range(0, 4095));
        c.gain_now  = GAIN_W'($urandom_range(0, 16383));
        c.gain_prev = GAIN_W'($urandom_range(0, 16383));
        c.drive_max = DW'($urandom_range(1000, 4095));
        return c;
    endfunction

    function automatic int pick_pause();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin : status_check
        t_out_word want;
        if (rst_n && out_valid && !out_stall) begin
            if (predicted_status.size() == 0) begin
                $display("%0t: unexpected status word %h", $time, out_word);
                mismatches++;
            end else begin
                want = predicted_status.pop_front();
                check_field("dac_write", 16'(want.dac_write), 16'(out_word.dac_write));
                check_field("dac_value", 16'(want.dac_value), 16'(out_word.dac_value));
                check_field("hv_enable", 16'(want.hv_enable), 16'(out_word.hv_enable));
                check_field("setpoint", 16'(want.setpoint), 16'(out_word.setpoint));
                check_field("tone", 16'(want.tone), 16'(out_word.tone));
                check_field("avg_valid", 16'(want.avg_valid), 16'(out_word.avg_valid));
                check_field("avg_voltage", 16'(want.avg_voltage),
                            16'(out_word.avg_voltage));
                check_field("avg_current", 16'(want.avg_current),
                            16'(out_word.avg_current));
                check_field("voltage_changed", 16'(want.voltage_changed),
                            16'(out_word.voltage_changed));
                check_field("current_changed", 16'(want.current_changed),
                            16'(out_word.current_changed));
            end
        end
    end

    initial begin : out_pacing
        int run;
        run = 0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (run > 0) begin
                run--;
                out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
                run = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 2);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic issue_word(input t_in_word w);
        int pause;
        pause = pick_pause();
        if (pause > 0) begin
            in_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predicted_status.push_back(compute_status(w));
    endtask

    task automatic settle_outputs();
        in_valid <= 1'b0;
        while (predicted_status.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SP_MIN:    knobs.sp_min    = val[DW-1:0];
            CFG_SP_MAX:    knobs.sp_max    = val[DW-1:0];
            CFG_STEP:      knobs.step_size = val[STEP_W-1:0];
            CFG_ERR_LIM:   knobs.err_limit = val[DW-1:0];
            CFG_GAIN_NOW:  knobs.gain_now  = val[GAIN_W-1:0];
            CFG_GAIN_PREV: knobs.gain_prev = val[GAIN_W-1:0];
            CFG_DRIVE_MAX: knobs.drive_max = val[DW-1:0];
            default: begin
            end
        endcase
        @(posedge clk);
    endtask

    task automatic load_settings(input t_cfg c);
        write_reg(CFG_SP_MIN, CFG_DW'(c.sp_min));
        write_reg(CFG_SP_MAX, CFG_DW'(c.sp_max));
        write_reg(CFG_STEP, CFG_DW'(c.step_size));
        write_reg(CFG_ERR_LIM, CFG_DW'(c.err_limit));
        write_reg(CFG_GAIN_NOW, CFG_DW'(c.gain_now));
        write_reg(CFG_GAIN_PREV, CFG_DW'(c.gain_prev));
        write_reg(CFG_DRIVE_MAX, CFG_DW'(c.drive_max));
    endtask

    task automatic test_directed_cases();
        issue_word(make_word(MODE_SAMPLE, 12'hFFF, 12'hFFF, 1'b1, 1'b1, 1'b1));
        issue_word(make_word(MODE_SAMPLE, 12'h000, 12'h000, 1'b0, 1'b0, 1'b0));
        issue_word(make_word(MODE_STEP, 12'h000, 12'h000, 1'b1, 1'b1, 1'b0));
        issue_word(make_word(MODE_STEP, 12'hFFF, 12'hFFF, 1'b0, 1'b0, 1'b1));
        issue_word(make_word(MODE_STEP, 12'h000, 12'h000, 1'b0, 1'b1, 1'b0));
        issue_word(make_word(MODE_SWITCH, 12'h000, 12'h000, 1'b0, 1'b0, 1'b1));
        issue_word(make_word(MODE_SWITCH, 12'h000, 12'h000, 1'b1, 1'b1, 1'b0));
        issue_word(make_word(MODE_SAMPLE, 12'h800, 12'h7FF, 1'b0, 1'b0, 1'b0));
        issue_word(make_word(MODE_STEP, 12'h000, 12'h000, 1'b0, 1'b1, 1'b0));
        issue_word(make_word(MODE_SWITCH, 12'h000, 12'h000, 1'b0, 1'b0, 1'b0));
        issue_word(make_word(MODE_IDLE, 12'hFFF, 12'hFFF, 1'b1, 1'b1, 1'b1));
        while (n_samples != 0)
            issue_word(make_word(MODE_SAMPLE, (n_samples % 2) ? 12'h000 : 12'hFFF,
                                 12'hFFF, 1'b0, 1'b0, 1'b0));
        settle_outputs();
    endtask

    task automatic test_setpoint_limits();
        write_reg(CFG_STEP, CFG_DW'(255));
        repeat (16) issue_word(make_word(MODE_STEP, 12'h000, 12'h000, 1'b0, 1'b1, 1'b0));
        issue_word(make_word(MODE_SAMPLE, 12'h000, 12'h000, 1'b0, 1'b0, 1'b0));
        issue_word(make_word(MODE_SAMPLE, 12'hFFF, 12'hFFF, 1'b0, 1'b0, 1'b0));
        repeat (16) issue_word(make_word(MODE_STEP, 12'h000, 12'h000, 1'b0, 1'b0, 1'b0));
        settle_outputs();
    endtask

    task automatic test_random_phase(input t_cfg c, input int count, input int calm,
                                     input bit flat);
        logic [DW-1:0] fv;
        logic [DW-1:0] fi;
        fv = DW'($urandom_range(0, 4095));
        fi = DW'($urandom_range(0, 4095));
        load_settings(c);
        for (int k = 0; k < count; k++) begin
            quiet = (k < calm);
            issue_word(random_word(flat, fv, fi));
            if ($urandom_range(0, 99) == 0) settle_outputs();
        end
        quiet = 1'b0;
        settle_outputs();
    endtask

    task automatic test_backpressure();
        quiet = 1'b1;
        hold_left = 120;
        repeat (40) issue_word(random_word(1'b0, '0, '0));
        quiet = 1'b0;
        settle_outputs();
    endtask

    initial begin
        reset_model();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed_cases();
        test_setpoint_limits();
        test_random_phase('{RST_SP_MIN, RST_SP_MAX, RST_STEP, RST_ERR_LIM,
                            RST_GAIN_NOW, RST_GAIN_PREV, RST_DRIVE_MAX}, 350, 150, 1'b0);
        test_backpressure();
        test_random_phase('{12'd0, 12'd4095, 8'd255, 12'd4095, 14'd16383, 14'd16383,
                            12'd4095}, 300, 0, 1'b0);
        test_random_phase('{12'd4095, 12'd0, 8'd1, 12'd0, 14'd0, 14'd0, 12'd0},
                          250, 0, 1'b1);
        test_random_phase(random_settings(), 250, 0, 1'b0);
        test_random_phase(random_settings(), 250, 0, 1'b1);
        test_random_phase(random_settings(), 250, 50, 1'b0);

        for (int k = 0; k < 20000 && predicted_status.size() != 0; k++) @(posedge clk);
        repeat (8) @(posedge clk);
        if (predicted_status.size() != 0) begin
            $display("%0t: %0d status words never arrived", $time, predicted_status.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("hv_supply_setpoint_regulator_core: match");
        else
            $display("hv_supply_setpoint_regulator_core: mismatch");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/hvsr_pkg.sv
design/hvsr_cfg.sv
design/hvsr_pi.sv
design/hvsr_avg.sv
design/hv_supply_setpoint_regulator_core.sv
test/hv_supply_setpoint_regulator_core_test.sv
